[design/pifi_pkg.sv]
// Package with shared constants, types and state encoding of the pair ID table.
package pifi_pkg;

  localparam int TABLE_DEPTH = 256;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int NODE_W      = 16;
  localparam int KEY_W       = 2 * NODE_W;
  localparam int ID_W        = 9;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SEARCH,
    S_DONE
  } state_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
  } rd_req_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [KEY_W-1:0]  data;
  } wr_req_t;

endpackage

[design/pifi_if.sv]
// Interfaces of the node pair input channel and the pair ID result channel.
interface pifi_in_if;
  logic                       valid;
  logic                       ready;
  logic [pifi_pkg::NODE_W-1:0] source_node;
  logic [pifi_pkg::NODE_W-1:0] target_node;

  modport source (output valid, output source_node, output target_node, input ready);
  modport sink (input valid, input source_node, input target_node, output ready);
endinterface

interface pifi_out_if;
  logic                      valid;
  logic                      ready;
  logic [pifi_pkg::ID_W-1:0] pair_id;
  logic                      was_found;
  logic                      table_full;

  modport source (output valid, output pair_id, output was_found, output table_full,
                  input ready);
  modport sink (input valid, input pair_id, input was_found, input table_full,
                output ready);
endinterface

[design/pifi_store.sv]
// Pair memory: one write port and one read port with registered read data.
module pifi_store (
  input  logic                         clk,
  input  pifi_pkg::rd_req_t            rd_req,
  output logic [pifi_pkg::KEY_W-1:0]   rd_data,
  input  pifi_pkg::wr_req_t            wr_req
);

  logic [pifi_pkg::KEY_W-1:0] mem [pifi_pkg::TABLE_DEPTH];

  always_ff @(posedge clk) begin
    if (wr_req.en) begin
      mem[wr_req.addr] <= wr_req.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_req.en) begin
      rd_data <= mem[rd_req.addr];
    end
  end

endmodule

[design/pair_id_find_or_insert_top.sv]
// Top level of the pair ID find-or-insert table.
//
// Each transaction on the input channel carries a node pair that is searched
// in the pair memory oldest entry first, one entry per cycle through the
// memory's single read port. A match returns its position plus one with
// was_found set; a miss appends the pair and returns the new entry count;
// a miss on a full table inserts nothing and returns pair_id 0 with
// table_full set. A new pair is accepted only after the previous one has
// finished its search and handed its result on. The result sits in an
// output register, so a new item is taken while a result waits.
// The memory needs no clearing after reset: only entries below the count
// are ever read.
module pair_id_find_or_insert_top (
  input  logic         clk,
  input  logic         rst_n,
  pifi_in_if.sink      in_ch,
  pifi_out_if.source   out_ch
);

  pifi_pkg::state_t                 state_r, state_nxt;
  logic [pifi_pkg::KEY_W-1:0]       key_r, key_nxt;
  logic [pifi_pkg::CNT_W-1:0]       count_r, count_nxt;
  logic [pifi_pkg::CNT_W-1:0]       rd_idx_r, rd_idx_nxt;
  logic                             cmp_vld_r, cmp_vld_nxt;
  logic [pifi_pkg::ADDR_W-1:0]      cmp_idx_r, cmp_idx_nxt;
  logic [pifi_pkg::ID_W-1:0]        res_id_r, res_id_nxt;
  logic                             res_found_r, res_found_nxt;
  logic                             res_full_r, res_full_nxt;
  logic                             out_valid_r, out_valid_nxt;
  logic [pifi_pkg::ID_W-1:0]        out_id_r, out_id_nxt;
  logic                             out_found_r, out_found_nxt;
  logic                             out_full_r, out_full_nxt;

  pifi_pkg::rd_req_t                rd_req;
  pifi_pkg::wr_req_t                wr_req;
  logic [pifi_pkg::KEY_W-1:0]       rd_data;

  logic                             issue;
  logic                             hit;
  logic                             out_free;
  logic                             in_take;

  pifi_store u_store (
    .clk     (clk),
    .rd_req  (rd_req),
    .rd_data (rd_data),
    .wr_req  (wr_req)
  );

  assign in_ch.ready       = (state_r == pifi_pkg::S_IDLE);
  assign in_take           = in_ch.valid && in_ch.ready;
  assign out_free          = !out_valid_r || out_ch.ready;

  assign out_ch.valid      = out_valid_r;
  assign out_ch.pair_id    = out_id_r;
  assign out_ch.was_found  = out_found_r;
  assign out_ch.table_full = out_full_r;

  assign issue = (state_r == pifi_pkg::S_SEARCH) && (rd_idx_r < count_r);
  assign hit   = (state_r == pifi_pkg::S_SEARCH) && cmp_vld_r && (rd_data == key_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= pifi_pkg::S_IDLE;
      count_r     <= '0;
      cmp_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      cmp_vld_r   <= cmp_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r       <= key_nxt;
    rd_idx_r    <= rd_idx_nxt;
    cmp_idx_r   <= cmp_idx_nxt;
    res_id_r    <= res_id_nxt;
    res_found_r <= res_found_nxt;
    res_full_r  <= res_full_nxt;
    out_id_r    <= out_id_nxt;
    out_found_r <= out_found_nxt;
    out_full_r  <= out_full_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    key_nxt       = key_r;
    count_nxt     = count_r;
    rd_idx_nxt    = rd_idx_r;
    cmp_vld_nxt   = 1'b0;
    cmp_idx_nxt   = cmp_idx_r;
    res_id_nxt    = res_id_r;
    res_found_nxt = res_found_r;
    res_full_nxt  = res_full_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_id_nxt    = out_id_r;
    out_found_nxt = out_found_r;
    out_full_nxt  = out_full_r;
    rd_req.en     = issue;
    rd_req.addr   = rd_idx_r[pifi_pkg::ADDR_W-1:0];
    wr_req.en     = 1'b0;
    wr_req.addr   = count_r[pifi_pkg::ADDR_W-1:0];
    wr_req.data   = key_r;

    unique case (state_r)
      pifi_pkg::S_IDLE: begin
        if (in_take) begin
          key_nxt    = {in_ch.source_node, in_ch.target_node};
          rd_idx_nxt = '0;
          state_nxt  = pifi_pkg::S_SEARCH;
        end
      end
      pifi_pkg::S_SEARCH: begin
        cmp_idx_nxt = rd_idx_r[pifi_pkg::ADDR_W-1:0];
        if (hit) begin
          res_id_nxt    = (pifi_pkg::ID_W)'((pifi_pkg::CNT_W)'(cmp_idx_r)
                                           + (pifi_pkg::CNT_W)'(1));
          res_found_nxt = 1'b1;
          res_full_nxt  = 1'b0;
          state_nxt     = pifi_pkg::S_DONE;
        end else if (issue) begin
          rd_idx_nxt  = rd_idx_r + (pifi_pkg::CNT_W)'(1);
          cmp_vld_nxt = 1'b1;
        end else begin
          res_found_nxt = 1'b0;
          state_nxt     = pifi_pkg::S_DONE;
          if (count_r == (pifi_pkg::CNT_W)'(pifi_pkg::TABLE_DEPTH)) begin
            res_id_nxt   = '0;
            res_full_nxt = 1'b1;
          end else begin
            wr_req.en    = 1'b1;
            count_nxt    = count_r + (pifi_pkg::CNT_W)'(1);
            res_id_nxt   = (pifi_pkg::ID_W)'(count_r + (pifi_pkg::CNT_W)'(1));
            res_full_nxt = 1'b0;
          end
        end
      end
      pifi_pkg::S_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_id_nxt    = res_id_r;
          out_found_nxt = res_found_r;
          out_full_nxt  = res_full_r;
          state_nxt     = pifi_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = pifi_pkg::S_IDLE;
      end
    endcase
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= (pifi_pkg::CNT_W)'(pifi_pkg::TABLE_DEPTH))
    else $error("entry count above table depth");

  a_write_not_full: assert property (@(posedge clk) disable iff (!rst_n)
    wr_req.en |-> count_r < (pifi_pkg::CNT_W)'(pifi_pkg::TABLE_DEPTH))
    else $error("insert into full table");

  a_full_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_full_r) |->
      (count_r == (pifi_pkg::CNT_W)'(pifi_pkg::TABLE_DEPTH)) && !out_found_r
      && (out_id_r == '0))
    else $error("full result with free entries");

  a_accept_search: assert property (@(posedge clk) disable iff (!rst_n)
    in_take |=> (state_r == pifi_pkg::S_SEARCH) && !cmp_vld_r)
    else $error("accepted transaction did not start a search");

  a_no_read_while_idle: assert property (@(posedge clk) disable iff (!rst_n)
    rd_req.en |-> (state_r == pifi_pkg::S_SEARCH) && !wr_req.en)
    else $error("memory read outside search");

endmodule
